>>> rtl/core/ndgh_pkg.sv
`default_nettype none

package ndgh_pkg;

	localparam int unsigned CNT_W = 32;
	localparam logic [CNT_W-1:0] NO_NEIGHBOR = 32'd999999;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	typedef enum logic [1:0] {
		ST_CLEAR = 2'b01,
		ST_RUN   = 2'b10
	} hist_state_t;

	// one histogram access: a run close (read-modify-write) or a bin read
	typedef struct packed {
		logic             is_bin;
		logic [CNT_W-1:0] key;    // gap of the run, or requested bin index
		logic [CNT_W-1:0] tally;
		logic             last;
	} hist_op_t;

endpackage

`default_nettype wire

>>> rtl/core/ndgh_hist_ram.sv
`default_nettype none

module ndgh_hist_ram import ndgh_pkg::*; #(
	parameter int unsigned DEPTH = 10001,
	parameter int unsigned AW    = 14
) (
	input  wire logic             clk,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output      logic [CNT_W-1:0] rdata,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [CNT_W-1:0] wdata
);

	logic [CNT_W-1:0] mem [DEPTH];

	// read returns the old word when the same entry is written in that cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/nearest_distinct_gap_histogram.sv
`default_nettype none

// channel  signals                                      role
// input    in_valid/in_ready: kind position             tag or bin read request
//          chrom_last bin_index
// output   out_valid/out_ready: result_kind gap         run report or bin value
//          run_length bin_count last
//
// A tag that closes two runs queues two ops, which issue to the histogram memory one
// at a time; in_ready stays low until the queue can take the next item.
// Results pass through the op queue, the memory read stage and the output register.
// After reset the histogram is swept to zero with in_ready low. A stalled
// output holds the memory stage and then the queue.

module nearest_distinct_gap_histogram import ndgh_pkg::*; #(
	parameter int unsigned HIST_BINS = 10000
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic        kind,
	input  wire logic [31:0] position,
	input  wire logic        chrom_last,
	input  wire logic [13:0] bin_index,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic        result_kind,
	output      logic [31:0] gap,
	output      logic [31:0] run_length,
	output      logic [31:0] bin_count,
	output      logic        last
);

	localparam int unsigned DEPTH = HIST_BINS + 1;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam logic [AW-1:0] OVF_BIN = AW'(HIST_BINS);
	localparam logic [CNT_W-1:0] BINS_W = CNT_W'(HIST_BINS);

	// run state
	logic [CNT_W-1:0] run_pos_q;
	logic [CNT_W-1:0] run_tally_q;
	logic             run_open_q;
	logic [CNT_W-1:0] dprev_q;   // distance to the earlier distinct run

	// op queue, two slots
	hist_op_t   slot0_q, slot1_q;
	logic [1:0] cnt_q;

	// memory stage
	hist_op_t         op_s1;
	logic [AW-1:0]    addr_s1;
	logic             valid_s1;

	// last write, for read-after-write forwarding
	logic [AW-1:0]    wr_addr_q;
	logic [CNT_W-1:0] wr_data_q;
	logic             wr_valid_q;

	// clearing sweep
	hist_state_t state_q;
	logic [AW-1:0] clr_addr_q;

	logic out_valid_q;
	logic result_kind_q, last_q;
	logic [CNT_W-1:0] gap_q, run_length_q, bin_count_q;

	logic adv_s1, issue, accept;
	logic same, close1;
	logic [CNT_W-1:0] dnext, g1, g2, tally_inc;
	logic [CNT_W-1:0] dprev_min, dnext_min;
	hist_op_t op1, op2, bin_op, op_a, op_b;
	logic [1:0] n_ops;
	logic [AW-1:0] issue_addr;
	logic [CNT_W-1:0] rdata, cur, new_val;
	logic [CNT_W:0] sum;
	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [CNT_W-1:0] mem_wdata;

	assign adv_s1 = valid_s1 && (!out_valid_q || out_ready);
	assign issue = (cnt_q != 2'd0) && (!valid_s1 || adv_s1);
	assign in_ready = (state_q == ST_RUN) &&
		((cnt_q == 2'd0) || ((cnt_q == 2'd1) && issue));
	assign accept = in_valid && in_ready;

	// ---- run tracking and op generation
	always_comb begin
		same = run_open_q && (position == run_pos_q);
		close1 = run_open_q && !same;
		dnext = (position > run_pos_q) ? (position - run_pos_q) : (run_pos_q - position);
		g1 = (dnext < dprev_q) ? dnext : dprev_q;
		dprev_min = (dprev_q < NO_NEIGHBOR) ? dprev_q : NO_NEIGHBOR;
		dnext_min = (dnext < NO_NEIGHBOR) ? dnext : NO_NEIGHBOR;
		g2 = close1 ? dnext_min : dprev_min;
		tally_inc = (run_tally_q == CNT_MAX) ? run_tally_q : run_tally_q + 1'b1;

		op1.is_bin = 1'b0;
		op1.key = g1;
		op1.tally = run_tally_q;
		op1.last = !chrom_last;

		op2.is_bin = 1'b0;
		op2.key = g2;
		op2.tally = same ? tally_inc : CNT_W'(1);
		op2.last = 1'b1;

		bin_op.is_bin = 1'b1;
		bin_op.key = CNT_W'(bin_index);
		bin_op.tally = '0;
		bin_op.last = 1'b1;

		if (kind) begin
			op_a = bin_op;
			op_b = bin_op;
			n_ops = 2'd1;
		end else begin
			op_a = close1 ? op1 : op2;
			op_b = op2;
			n_ops = {1'b0, close1} + {1'b0, chrom_last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_pos_q <= '0;
			run_tally_q <= '0;
			run_open_q <= 1'b0;
			dprev_q <= NO_NEIGHBOR;
		end else if (accept && !kind) begin
			if (chrom_last) begin
				run_pos_q <= '0;
				run_tally_q <= '0;
				run_open_q <= 1'b0;
				dprev_q <= NO_NEIGHBOR;
			end else if (same) begin
				run_tally_q <= tally_inc;
			end else begin
				run_pos_q <= position;
				run_tally_q <= CNT_W'(1);
				run_open_q <= 1'b1;
				if (close1) begin
					dprev_q <= dnext;
				end
			end
		end
	end

	// ---- op queue; accept only happens when it is empty or drains this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= n_ops;
		end else if (issue) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot0_q <= op_a;
			slot1_q <= op_b;
		end else if (issue) begin
			slot0_q <= slot1_q;
		end
	end

	// overflow bin takes large gaps and out-of-range indexes alike
	assign issue_addr = (slot0_q.key >= BINS_W) ? OVF_BIN : slot0_q.key[AW-1:0];

	// ---- memory stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue || (valid_s1 && !adv_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			op_s1 <= slot0_q;
			addr_s1 <= issue_addr;
		end
	end

	always_comb begin
		cur = (wr_valid_q && (wr_addr_q == addr_s1)) ? wr_data_q : rdata;
		sum = {1'b0, cur} + {1'b0, op_s1.tally};
		new_val = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (adv_s1 && !op_s1.is_bin) begin
			wr_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && !op_s1.is_bin) begin
			wr_addr_q <= addr_s1;
			wr_data_q <= new_val;
		end
	end

	// ---- clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == OVF_BIN) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_CLEAR;
					clr_addr_q <= '0;
				end
			endcase
		end
	end

	always_comb begin
		if (state_q == ST_RUN) begin
			mem_we = adv_s1 && !op_s1.is_bin;
			mem_waddr = addr_s1;
			mem_wdata = new_val;
		end else begin
			mem_we = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end
	end

	ndgh_hist_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.re   (issue),
		.raddr(issue_addr),
		.rdata(rdata),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata)
	);

	// ---- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= adv_s1 || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_kind_q <= op_s1.is_bin;
			last_q <= op_s1.last;
			gap_q <= op_s1.is_bin ? '0 : op_s1.key;
			run_length_q <= op_s1.is_bin ? '0 : op_s1.tally;
			bin_count_q <= op_s1.is_bin ? cur : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = result_kind_q;
	assign gap = gap_q;
	assign run_length = run_length_q;
	assign bin_count = bin_count_q;
	assign last = last_q;

endmodule

`default_nettype wire

>>> verif/nearest_distinct_gap_histogram_tb.sv
`timescale 1ns / 1ps

module nearest_distinct_gap_histogram_tb;
	import ndgh_pkg::*;

	localparam int unsigned HIST_BINS = 10000;
	localparam logic KIND_TAG = 1'b0;
	localparam logic KIND_BIN = 1'b1;
	localparam logic RES_RUN = 1'b0;
	localparam logic RES_BIN = 1'b1;
	localparam int unsigned N_RANDOM = 1300;

	typedef struct {
		logic        kind;
		logic [31:0] position;
		logic        chrom_last;
		logic [13:0] bin_index;
		bit          drain;
	} tag_item_t;

	typedef struct {
		logic        result_kind;
		logic [31:0] gap;
		logic [31:0] run_length;
		logic [31:0] bin_count;
		logic        last;
	} gap_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        kind = 1'b0;
	logic [31:0] position = '0;
	logic        chrom_last = 1'b0;
	logic [13:0] bin_index = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        result_kind;
	logic [31:0] gap;
	logic [31:0] run_length;
	logic [31:0] bin_count;
	logic        last;

	tag_item_t   pending_items[$];
	gap_report_t expected_reports[$];
	int unsigned items_pushed = 0;
	int unsigned items_sent = 0;
	int unsigned err_count = 0;
	int unsigned n_tags = 0, n_bin_reads = 0, n_run_reports = 0, n_chrom_ends = 0;
	int unsigned n_checked = 0;

	// mirror of the block state
	logic [31:0] run_pos_m;
	logic [31:0] run_tally_m;
	bit          run_open_m;
	logic [31:0] earlier_pos_m;
	bit          earlier_valid_m;
	logic [31:0] hist_m [0:HIST_BINS];

	nearest_distinct_gap_histogram #(
		.HIST_BINS(HIST_BINS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.position(position),
		.chrom_last(chrom_last),
		.bin_index(bin_index),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.gap(gap),
		.run_length(run_length),
		.bin_count(bin_count),
		.last(last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [31:0] abs_gap(input logic [31:0] a, input logic [31:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	task automatic close_open_run(input bit next_valid, input logic [31:0] next_pos,
			input logic is_last);
		logic [31:0] dprev, dnext, g;
		logic [32:0] sum;
		int unsigned b;
		gap_report_t rep;
		dprev = earlier_valid_m ? abs_gap(run_pos_m, earlier_pos_m) : NO_NEIGHBOR;
		dnext = next_valid ? abs_gap(run_pos_m, next_pos) : NO_NEIGHBOR;
		g = (dnext < dprev) ? dnext : dprev;
		b = (g >= HIST_BINS) ? HIST_BINS : g;
		sum = {1'b0, hist_m[b]} + {1'b0, run_tally_m};
		hist_m[b] = sum[32] ? CNT_MAX : sum[31:0];
		rep.result_kind = RES_RUN;
		rep.gap = g;
		rep.run_length = run_tally_m;
		rep.bin_count = '0;
		rep.last = is_last;
		expected_reports.insert(expected_reports.size(), rep);
		n_run_reports++;
	endtask

	task automatic predict_item(input tag_item_t it);
		gap_report_t rep;
		int unsigned idx;
		if (it.kind == KIND_BIN) begin
			idx = (it.bin_index > HIST_BINS) ? HIST_BINS : it.bin_index;
			rep.result_kind = RES_BIN;
			rep.gap = '0;
			rep.run_length = '0;
			rep.bin_count = hist_m[idx];
			rep.last = 1'b1;
			expected_reports.insert(expected_reports.size(), rep);
			n_bin_reads++;
		end else begin
			n_tags++;
			if (run_open_m && it.position == run_pos_m) begin
				if (run_tally_m != CNT_MAX)
					run_tally_m++;
			end else begin
				if (run_open_m) begin
					close_open_run(1'b1, it.position, !it.chrom_last);
					earlier_pos_m = run_pos_m;
					earlier_valid_m = 1'b1;
				end
				run_pos_m = it.position;
				run_tally_m = 32'd1;
				run_open_m = 1'b1;
			end
			if (it.chrom_last) begin
				close_open_run(1'b0, '0, 1'b1);
				run_pos_m = '0;
				run_tally_m = '0;
				run_open_m = 1'b0;
				earlier_pos_m = '0;
				earlier_valid_m = 1'b0;
				n_chrom_ends++;
			end
		end
	endtask

	function automatic bit idle_now();
		// no idling on either side through the middle of the run
		if (items_sent >= 500 && items_sent < 700)
			return 1'b0;
		return $urandom_range(99) < 27;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		tag_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				it.kind = kind;
				it.position = position;
				it.chrom_last = chrom_last;
				it.bin_index = bin_index;
				it.drain = 1'b0;
				predict_item(it);
				items_sent++;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && !idle_now() &&
						!(pending_items[0].drain && expected_reports.size() != 0)) begin
					it = pending_items.pop_front();
					in_valid <= 1'b1;
					kind <= it.kind;
					position <= it.position;
					chrom_last <= it.chrom_last;
					bin_index <= it.bin_index;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		gap_report_t exp_rep;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: unexpected transaction kind=%0d gap=%0d run=%0d bin=%0d last=%0d",
						$realtime, result_kind, gap, run_length, bin_count, last);
					err_count++;
				end else begin
					exp_rep = expected_reports.pop_front();
					n_checked++;
					if (result_kind !== exp_rep.result_kind) begin
						$display("%0t: result_kind expected %0d actual %0d",
							$realtime, exp_rep.result_kind, result_kind);
						err_count++;
					end
					if (gap !== exp_rep.gap) begin
						$display("%0t: gap expected %0d actual %0d", $realtime, exp_rep.gap, gap);
						err_count++;
					end
					if (run_length !== exp_rep.run_length) begin
						$display("%0t: run_length expected %0d actual %0d",
							$realtime, exp_rep.run_length, run_length);
						err_count++;
					end
					if (bin_count !== exp_rep.bin_count) begin
						$display("%0t: bin_count expected %0d actual %0d",
							$realtime, exp_rep.bin_count, bin_count);
						err_count++;
					end
					if (last !== exp_rep.last) begin
						$display("%0t: last expected %0d actual %0d", $realtime, exp_rep.last, last);
						err_count++;
					end
				end
			end
			out_ready <= !idle_now();
		end
	end

	task automatic push_item(input logic k, input logic [31:0] pos, input logic cl,
			input logic [13:0] idx);
		tag_item_t it;
		it.kind = k;
		it.position = pos;
		it.chrom_last = cl;
		it.bin_index = idx;
		// hold the sender until the block has drained, a couple of times
		it.drain = (items_pushed == 450 || items_pushed == 950);
		pending_items.insert(pending_items.size(), it);
		items_pushed++;
	endtask

	task automatic push_tag(input logic [31:0] pos, input logic cl);
		push_item(KIND_TAG, pos, cl, 14'($urandom()));
	endtask

	task automatic push_bin(input logic [13:0] idx);
		push_item(KIND_BIN, $urandom(), 1'($urandom()), idx);
	endtask

	function automatic logic [13:0] pick_bin();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return 14'($urandom_range(60));
		else if (r < 70)
			return 14'($urandom_range(HIST_BINS + 10, HIST_BINS - 10));
		else if (r < 80)
			return 14'(HIST_BINS);
		return 14'($urandom());
	endfunction

	function automatic logic [31:0] pick_step();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30)
			return '0;
		else if (r < 75)
			return $urandom_range(40, 1);
		else if (r < 88)
			return $urandom_range(HIST_BINS + 10, HIST_BINS - 10);
		else if (r < 95)
			return $urandom_range(2000, 40);
		return $urandom();
	endfunction

	initial begin
		int unsigned r, len;
		logic [31:0] pos;
		bit down;
		for (int i = 0; i <= HIST_BINS; i++)
			hist_m[i] = '0;
		run_pos_m = '0;
		run_tally_m = '0;
		run_open_m = 1'b0;
		earlier_pos_m = '0;
		earlier_valid_m = 1'b0;

		// directed: empty histogram, bounds of the bin index
		push_bin(14'd0);
		push_bin(14'h3FFF);
		// lone tag: both sides missing, lands in overflow
		push_tag(32'd0, 1'b1);
		push_bin(14'(HIST_BINS));
		// run of three, bin read while the run is open, run closed by a new position
		push_tag(32'd100, 1'b0);
		push_tag(32'd100, 1'b0);
		push_bin(14'd5);
		push_tag(32'd100, 1'b0);
		push_tag(32'd105, 1'b0);
		// end mark on a repeated position
		push_tag(32'd105, 1'b1);
		push_bin(14'd5);
		// new position together with the end mark: two reports from one transaction
		push_tag(32'd200, 1'b0);
		push_tag(32'hFFFF_FFFF, 1'b1);
		// far neighbors on both sides give a gap beyond the no-neighbor value
		push_tag(32'd0, 1'b0);
		push_tag(32'h8000_0000, 1'b0);
		push_tag(32'hFFFF_FFFF, 1'b1);
		// descending positions, gap at the overflow boundary
		push_tag(32'd20500, 1'b0);
		push_tag(32'd10500, 1'b0);
		push_tag(32'd501, 1'b1);
		push_bin(14'(HIST_BINS - 1));
		push_bin(14'(HIST_BINS));
		push_bin(14'(HIST_BINS + 1));
		push_bin(14'h2AAA);
		push_bin(14'h1555);

		while (items_pushed < N_RANDOM) begin
			r = $urandom_range(99);
			if (r < 8) begin
				push_tag($urandom(), 1'($urandom()));
			end else if (r < 20) begin
				push_bin(pick_bin());
			end else begin
				r = $urandom_range(99);
				if (r < 50)
					pos = $urandom_range(2000000);
				else if (r < 75)
					pos = $urandom();
				else
					pos = 32'hFFFF_FFFF - $urandom_range(500);
				down = ($urandom_range(99) < 20);
				len = $urandom_range(12, 1);
				for (int k = 0; k < len; k++) begin
					push_tag(pos, k == len - 1);
					if ($urandom_range(99) < 10)
						push_bin(pick_bin());
					pos = down ? pos - pick_step() : pos + pick_step();
				end
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_items.size() != 0 || in_valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_reports.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $realtime,
				expected_reports.size());
			err_count++;
		end
		$display("covered %0d tags over %0d chromosome ends, %0d bin reads",
			n_tags, n_chrom_ends, n_bin_reads);
		$display("checked %0d results, %0d run reports, %0d mismatches",
			n_checked, n_run_reports, err_count);
		if (err_count == 0) begin
			$display("nearest_distinct_gap_histogram test passed");
		end else begin
			$display("nearest_distinct_gap_histogram test failed");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("%0t: timeout", $realtime);
		$display("nearest_distinct_gap_histogram test failed");
		$finish;
	end

endmodule
